### hdl/tih_pkg.sv
// ----------------------------------------------------------------------------
// tih_pkg: shared types and constants for the tour insertion block
// Holds store geometry, fixed-point widths and the sequencer state codes.
// ----------------------------------------------------------------------------
package tih_pkg;

  localparam int MaxPoints = 1024;
  localparam int CoordBits = 16;
  localparam int FracBits  = 8;
  localparam int SlotBits  = $clog2(MaxPoints);
  localparam int CountBits = SlotBits + 1;
  localparam int SqBits    = 2 * CoordBits + 1;
  localparam int RootBits  = CoordBits + 1 + FracBits;
  localparam int RootSteps = RootBits;
  localparam int StepBits  = $clog2(RootSteps + 1);
  localparam int EdgeBits  = 25;
  localparam int LenBits   = 35;
  localparam int CostBits  = RootBits + 2;

  typedef logic [CoordBits-1:0] coord_t;
  typedef logic [SlotBits-1:0]  slot_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [RootBits-1:0]  root_t;
  typedef logic [LenBits-1:0]   len_t;

  typedef enum logic [11:0] {
    StIdle   = 12'b000000000001,
    StRdCur  = 12'b000000000010,
    StWtCur  = 12'b000000000100,
    StRtCur  = 12'b000000001000,
    StRdNxt  = 12'b000000010000,
    StWtNxt  = 12'b000000100000,
    StRtNxt  = 12'b000001000000,
    StCmp    = 12'b000010000000,
    StFinA   = 12'b000100000000,
    StFinB   = 12'b001000000000,
    StWrite  = 12'b010000000000,
    StOut    = 12'b100000000000
  } state_e;

endpackage

### hdl/tih_ram.sv
// ----------------------------------------------------------------------------
// tih_ram: generic single-port RAM
// One read a cycle, plus a write when enabled; registered read data.
// ----------------------------------------------------------------------------
module tih_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

### hdl/tour_insertion_heuristic_top.sv
// Flow: the first point is written to slot 0 with no root. A later point walks
//   the stored ring on the one shared bit-serial root unit: one root per point
//   walked in nearest mode, two in cheapest, and two more to link the new point.
//   A full store skips the walk and flags status.
// Throughput: one point at a time; in_stall_o is high from accept until the
//   result word is taken.
// Reset: point count, tour length and mode clear; the stores are not cleared.
// ----------------------------------------------------------------------------
// tour_insertion_heuristic_top: incremental TSP tour builder
// Walks the ring with one sqrt unit, links the new point; flags a full store.
// ----------------------------------------------------------------------------
module tour_insertion_heuristic_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [15:0]               point_x_i,
  input  logic [15:0]               point_y_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      status_o,
  output logic [9:0]                new_slot_o,
  output logic [9:0]                after_slot_o,
  output logic [10:0]               tour_size_o,
  output logic [34:0]               tour_length_o
);
  import tih_pkg::*;

  state_e st_q, st_d;
  logic   mode_q;
  count_t cnt_q;
  len_t   len_q;
  coord_t px_q, py_q;
  slot_t  cur_q, nxt_q, best_q, after_q;
  count_t k_q;
  logic   have_q;
  logic signed [CostBits-1:0] best_cost_q;
  root_t  dcur_q, dnxt_q;
  logic [EdgeBits-1:0] ecur_q;
  logic   fin_q;   // set for the finish phase: roots to the chosen edge, then link

  // RAM access: one shared address
  slot_t  addr;
  coord_t xr, yr;
  slot_t  sr;
  logic [EdgeBits-1:0] er;
  logic   wx, ws, wed;
  coord_t wxd, wyd;
  slot_t  wsd;
  logic [EdgeBits-1:0] wedd;

  tih_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_x (
    .clk_i, .we_i(wx), .addr_i(addr), .wdata_i(wxd), .rdata_o(xr));
  tih_ram #(.Width(CoordBits), .Depth(MaxPoints)) u_y (
    .clk_i, .we_i(wx), .addr_i(addr), .wdata_i(wyd), .rdata_o(yr));
  tih_ram #(.Width(SlotBits), .Depth(MaxPoints)) u_s (
    .clk_i, .we_i(ws), .addr_i(addr), .wdata_i(wsd), .rdata_o(sr));
  tih_ram #(.Width(EdgeBits), .Depth(MaxPoints)) u_e (
    .clk_i, .we_i(wed), .addr_i(addr), .wdata_i(wedd), .rdata_o(er));

  // Shared bit-serial root unit
  // sq_q is one bit wider than the sum so the top pair sits on even bits
  logic [SqBits:0]    sq_q;
  logic [RootBits+1:0] rem_q;
  root_t              root_q;
  logic [StepBits-1:0] step_q;
  logic [CoordBits-1:0] dx, dy;
  logic [SqBits-1:0]  sq_new;
  logic [1:0]         pair;
  logic [RootBits+1:0] rem_sh, trial;
  logic               rt_start, rt_busy;

  assign dx = (xr > px_q) ? xr - px_q : px_q - xr;
  assign dy = (yr > py_q) ? yr - py_q : py_q - yr;
  // two narrow (16x16) squares, formed and summed combinationally
  assign sq_new = SqBits'(dx * dx) + SqBits'(dy * dy);
  assign pair   = (step_q > StepBits'(FracBits)) ?
                  sq_q[SqBits -: 2] : 2'b00;
  assign rem_sh = {rem_q[RootBits-1:0], pair};
  assign trial  = {root_q, 2'b01};
  assign rt_busy = (step_q != '0);

  always_ff @(posedge clk_i) begin
    if (rt_start) begin
      sq_q   <= {1'b0, sq_new};
      rem_q  <= '0;
      root_q <= '0;
    end else if (rt_busy) begin
      if (step_q > StepBits'(FracBits)) begin
        sq_q <= sq_q << 2;
      end
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[RootBits-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[RootBits-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (rt_start) begin
      step_q <= StepBits'(RootSteps);
    end else if (rt_busy) begin
      step_q <= step_q - 1'b1;
    end
  end

  logic signed [CostBits-1:0] cost;
  assign cost = mode_q ? (CostBits'(dcur_q) + CostBits'(dnxt_q) - CostBits'(ecur_q))
                       : CostBits'(dcur_q);

  logic in_acc, out_acc;
  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign in_stall_o  = (st_q != StIdle);
  assign cfg_ready_o = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);

  len_t len_new;
  assign len_new = len_q - LenBits'(ecur_q) + LenBits'(dcur_q) + LenBits'(dnxt_q);

  always_comb begin
    st_d = st_q;
    addr = cur_q;
    wx = 1'b0; ws = 1'b0; wed = 1'b0;
    wxd = px_q; wyd = py_q; wsd = nxt_q; wedd = '0;
    rt_start = 1'b0;
    case (st_q)
      StIdle:  if (in_acc) st_d = StRdCur;
      StRdCur: begin
        addr = fin_q ? after_q : cur_q;
        if (cnt_q == count_t'(MaxPoints)) st_d = StOut;
        else if (cnt_q == '0) st_d = StWrite;
        else st_d = StWtCur;
      end
      StWtCur: begin
        addr = fin_q ? after_q : cur_q;
        rt_start = 1'b1;
        st_d = StRtCur;
      end
      StRtCur: begin
        addr = nxt_q;
        if (!rt_busy) st_d = (mode_q || fin_q) ? StRdNxt : StCmp;
      end
      StRdNxt: begin addr = nxt_q; st_d = StWtNxt; end
      StWtNxt: begin addr = nxt_q; rt_start = 1'b1; st_d = StRtNxt; end
      StRtNxt: begin
        addr = nxt_q;
        if (!rt_busy) st_d = fin_q ? StFinA : StCmp;
      end
      StCmp: begin
        addr = nxt_q;
        st_d = StRdCur;
      end
      StFinA: begin
        // link new point: store coords, successor and edge of the new slot
        addr = slot_t'(cnt_q); wx = 1'b1; ws = 1'b1; wsd = nxt_q;
        wed = 1'b1; wedd = EdgeBits'(dnxt_q);
        st_d = StFinB;
      end
      StFinB: begin
        addr = after_q; ws = 1'b1; wsd = slot_t'(cnt_q);
        wed = 1'b1; wedd = EdgeBits'(dcur_q);
        st_d = StOut;
      end
      StWrite: begin
        addr = '0; wx = 1'b1; ws = 1'b1; wsd = '0; wed = 1'b1; wedd = '0;
        st_d = StOut;
      end
      StOut: if (out_acc) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; mode_q <= 1'b0; cnt_q <= '0; len_q <= '0; fin_q <= 1'b0;
      status_o <= 1'b0; new_slot_o <= '0; after_slot_o <= '0;
      tour_size_o <= '0; tour_length_o <= '0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i && cfg_ready_o) mode_q <= cfg_data_i;
      case (st_q)
        StIdle: if (in_acc) begin
          px_q <= point_x_i; py_q <= point_y_i;
          cur_q <= '0; k_q <= '0; have_q <= 1'b0; fin_q <= 1'b0;
        end
        StRdCur: if (cnt_q == count_t'(MaxPoints)) begin
          status_o <= 1'b1; new_slot_o <= '0; after_slot_o <= '0;
          tour_size_o <= cnt_q; tour_length_o <= len_q;
        end
        StWtCur: begin nxt_q <= sr; ecur_q <= er; end
        StRtCur: if (!rt_busy) dcur_q <= root_q;
        StRtNxt: if (!rt_busy) dnxt_q <= root_q;
        StCmp: begin
          if (!have_q || cost < best_cost_q) begin
            best_cost_q <= cost; best_q <= cur_q;
          end
          have_q <= 1'b1;
          cur_q <= nxt_q;
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 == cnt_q) begin
            fin_q <= 1'b1;
            after_q <= (!have_q || cost < best_cost_q) ? cur_q : best_q;
          end
        end
        StFinA: len_q <= len_new;
        StFinB: begin
          status_o <= 1'b0; new_slot_o <= slot_t'(cnt_q); after_slot_o <= after_q;
          tour_size_o <= cnt_q + 1'b1; tour_length_o <= len_q;
          cnt_q <= cnt_q + 1'b1;
        end
        StWrite: begin
          status_o <= 1'b0; new_slot_o <= '0; after_slot_o <= '0;
          tour_size_o <= count_t'(1); tour_length_o <= '0;
          cnt_q <= count_t'(1); len_q <= '0;
        end
        default: ;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != StIdle) |-> in_stall_o) else $error("stall low while busy");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= count_t'(MaxPoints)) else $error("count overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result lost");
  a_root_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rt_start |-> !rt_busy) else $error("root restarted while busy");
endmodule
